FILE: sv/kpc_pkg.sv
// Shared types, keyword tables and result codes for the keyword plausibility classifier.
package kpc_pkg;

  localparam int WINDOW_LEN_DEF = 20;
  localparam int COUNT_BITS_DEF = 32;

  localparam int KW_CHARS = 20;
  localparam int KW_BITS  = 8 * KW_CHARS;
  localparam int NUM_KW   = 14;

  localparam int OUT_DATA_BITS = 144;
  localparam int TOTAL_BITS    = 32;
  localparam int SCORE_BITS    = 7;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_PHYSICS  = 2'd1,
    KIND_RESOURCE = 2'd2,
    KIND_SCALE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    LEVEL_PLAUSIBLE   = 2'd0,
    LEVEL_IMPLAUSIBLE = 2'd1,
    LEVEL_IMPOSSIBLE  = 2'd2
  } level_t;

  localparam logic [SCORE_BITS-1:0] SCORE_NONE     = 7'd100;
  localparam logic [SCORE_BITS-1:0] SCORE_PHYSICS  = 7'd0;
  localparam logic [SCORE_BITS-1:0] SCORE_RESOURCE = 7'd20;
  localparam logic [SCORE_BITS-1:0] SCORE_SCALE    = 7'd30;

  typedef struct packed {
    logic physics;
    logic resource;
    logic scale;
  } hits_t;

  // Last character of each keyword sits in bits [7:0].
  localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KW] = '{
    KW_BITS'("perpetual motion"),
    KW_BITS'("faster than light"),
    KW_BITS'("infinite energy"),
    KW_BITS'("time travel"),
    KW_BITS'("teleport"),
    KW_BITS'("antigravity"),
    KW_BITS'("unlimited"),
    KW_BITS'("infinite resource"),
    KW_BITS'("costless"),
    KW_BITS'("free energy"),
    KW_BITS'("microscopic universe"),
    KW_BITS'("infinitely large"),
    KW_BITS'("zero volume"),
    KW_BITS'("instant construction")
  };

  localparam int KW_LEN [NUM_KW] = '{16, 17, 15, 11, 8, 11, 9, 17, 8, 11, 20, 16, 11, 20};

  localparam kind_t KW_GROUP [NUM_KW] = '{
    KIND_PHYSICS, KIND_PHYSICS, KIND_PHYSICS, KIND_PHYSICS, KIND_PHYSICS, KIND_PHYSICS,
    KIND_RESOURCE, KIND_RESOURCE, KIND_RESOURCE, KIND_RESOURCE,
    KIND_SCALE, KIND_SCALE, KIND_SCALE, KIND_SCALE
  };

endpackage

FILE: sv/keyword_plausibility_classifier.sv
// Top level of the keyword plausibility classifier: byte window, flags, counters, result register.
//
// Input stream: one statement byte per beat. tdata carries the byte, tuser says whether
// the beat holds a byte (0 marks a bare marker), tlast closes the statement.
// Output stream: one result beat per statement, sent for the beat that carries tlast.
// It holds the verdict (level, kind, feasible flag, score) and four running totals.
// Throughput: one input beat per cycle unless a closing beat waits for the output register;
// the keyword compares on the window run in parallel in the stage between the input
// register and the result register. A closing beat passes through the input register and
// then the output register, which offers its result beat.
// A stalled result holds in the output register; the stage ahead holds a closing beat
// until the register frees, other beats keep flowing, and input ready drops only when
// both are full. Reset clears the window, the keyword flags and all totals; totals are
// COUNT_BITS wide, wrap, and show in the low 32 bits of their fields.
module keyword_plausibility_classifier #(
  parameter int WINDOW_LEN = kpc_pkg::WINDOW_LEN_DEF,
  parameter int COUNT_BITS = kpc_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // char_code
  input  logic                              s_axis_tuser,  // carries_char
  input  logic                              s_axis_tlast,  // end_of_statement
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // level[1:0], violation_kind[3:2], feasible[4], score_percent[11:5],
  // checks_total[43:12], impossible_total[75:44], implausible_total[107:76],
  // physics_total[139:108], zero[143:140]
  output logic [kpc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
  import kpc_pkg::*;

  localparam int HIST_BITS = 8 * (WINDOW_LEN - 1);

  logic                  in_valid;
  logic [7:0]            in_char;
  logic                  in_carries;
  logic                  in_last;
  logic [HIST_BITS-1:0]  hist;
  hits_t                 seen;
  logic [COUNT_BITS-1:0] checks;
  logic [COUNT_BITS-1:0] impossible;
  logic [COUNT_BITS-1:0] implausible;
  logic [COUNT_BITS-1:0] physics;

  logic                  out_valid;
  level_t                out_level;
  kind_t                 out_kind;
  logic                  out_feasible;
  logic [SCORE_BITS-1:0] out_score;
  logic [TOTAL_BITS-1:0] out_checks;
  logic [TOTAL_BITS-1:0] out_impossible;
  logic [TOTAL_BITS-1:0] out_implausible;
  logic [TOTAL_BITS-1:0] out_physics;

  logic [8*WINDOW_LEN-1:0] win_full;
  hits_t                   hits;
  hits_t                   seen_next;
  logic                    out_free;
  logic                    stage_fire;
  logic                    close_fire;
  logic [COUNT_BITS-1:0]   checks_next;
  logic [COUNT_BITS-1:0]   impossible_next;
  logic [COUNT_BITS-1:0]   implausible_next;
  logic [COUNT_BITS-1:0]   physics_next;
  level_t                  level_next;
  kind_t                   kind_next;
  logic                    feasible_next;
  logic [SCORE_BITS-1:0]   score_next;

  assign win_full = {hist, in_char};

  kpc_match u_match (
    .win  (win_full[KW_BITS-1:0]),
    .hits (hits)
  );

  assign out_free      = !out_valid || m_axis_tready;
  assign stage_fire    = in_valid && (!in_last || out_free);
  assign close_fire    = stage_fire && in_last;
  assign s_axis_tready = !in_valid || stage_fire;

  assign seen_next = in_carries ? (seen | hits) : seen;

  always_comb begin
    checks_next      = checks + 1'b1;
    impossible_next  = impossible;
    implausible_next = implausible;
    physics_next     = physics;
    level_next       = LEVEL_PLAUSIBLE;
    kind_next        = KIND_NONE;
    feasible_next    = 1'b1;
    score_next       = SCORE_NONE;
    if (seen_next.physics) begin
      level_next      = LEVEL_IMPOSSIBLE;
      kind_next       = KIND_PHYSICS;
      feasible_next   = 1'b0;
      score_next      = SCORE_PHYSICS;
      impossible_next = impossible + 1'b1;
      physics_next    = physics + 1'b1;
    end else if (seen_next.resource) begin
      level_next       = LEVEL_IMPLAUSIBLE;
      kind_next        = KIND_RESOURCE;
      score_next       = SCORE_RESOURCE;
      implausible_next = implausible + 1'b1;
    end else if (seen_next.scale) begin
      level_next       = LEVEL_IMPLAUSIBLE;
      kind_next        = KIND_SCALE;
      score_next       = SCORE_SCALE;
      implausible_next = implausible + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      hist        <= '0;
      seen        <= '0;
      checks      <= '0;
      impossible  <= '0;
      implausible <= '0;
      physics     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (close_fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (stage_fire) begin
        if (in_last) begin
          hist        <= '0;
          seen        <= '0;
          checks      <= checks_next;
          impossible  <= impossible_next;
          implausible <= implausible_next;
          physics     <= physics_next;
        end else begin
          seen <= seen_next;
          if (in_carries) begin
            hist <= win_full[HIST_BITS-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_char    <= s_axis_tdata;
      in_carries <= s_axis_tuser;
      in_last    <= s_axis_tlast;
    end
    if (close_fire) begin
      out_level       <= level_next;
      out_kind        <= kind_next;
      out_feasible    <= feasible_next;
      out_score       <= score_next;
      out_checks      <= TOTAL_BITS'(checks_next);
      out_impossible  <= TOTAL_BITS'(impossible_next);
      out_implausible <= TOTAL_BITS'(implausible_next);
      out_physics     <= TOTAL_BITS'(physics_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_physics, out_implausible, out_impossible, out_checks,
                          out_score, out_feasible, out_kind, out_level};

  a_close_loads_result: assert property (@(posedge clk) disable iff (rst)
    close_fire |=> m_axis_tvalid)
    else $error("closing beat did not load a result");

  a_close_clears_flags: assert property (@(posedge clk) disable iff (rst)
    close_fire |=> (seen == '0) && (hist == '0))
    else $error("statement state not cleared after closing beat");

  a_feasible_matches_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_feasible == (out_kind != KIND_PHYSICS)))
    else $error("feasible flag disagrees with violation kind");

  a_checks_advance: assert property (@(posedge clk) disable iff (rst)
    close_fire |=> (checks == $past(checks) + 1'b1))
    else $error("check total did not advance on a closing beat");

endmodule

FILE: sv/kpc_match.sv
// Parallel keyword compare of the byte window ending at the newest byte.
module kpc_match (
  input  logic [kpc_pkg::KW_BITS-1:0] win,
  output kpc_pkg::hits_t              hits
);
  import kpc_pkg::*;

  logic [NUM_KW-1:0] hit;

  for (genvar k = 0; k < NUM_KW; k++) begin : g_kw
    localparam logic [KW_BITS-1:0] MASK = ~({KW_BITS{1'b1}} << (8 * KW_LEN[k]));
    assign hit[k] = ((win ^ KW_TEXT[k]) & MASK) == '0;
  end

  always_comb begin
    hits = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (hit[k]) begin
        case (KW_GROUP[k])
          KIND_PHYSICS:  hits.physics  = 1'b1;
          KIND_RESOURCE: hits.resource = 1'b1;
          KIND_SCALE:    hits.scale    = 1'b1;
          default:       hits.scale    = hits.scale;
        endcase
      end
    end
  end

endmodule

FILE: sim/kpc_verdict_checker.sv
// Checker for the keyword plausibility classifier: tracks both streams, predicts each verdict and compares.
module kpc_verdict_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_valid,
  input  logic                              s_ready,
  input  logic [7:0]                        s_data,
  input  logic                              s_user,
  input  logic                              s_last,
  input  logic                              m_valid,
  input  logic                              m_ready,
  input  logic [kpc_pkg::OUT_DATA_BITS-1:0] m_data,
  output int                                mismatches,
  output int                                pending
);
  import kpc_pkg::*;

  localparam int PHRASES  = 14;
  localparam int WIN_BITS = 8 * WINDOW_LEN_DEF;

  typedef struct {
    level_t      level;
    kind_t       kind;
    logic        feasible;
    logic [6:0]  score;
    logic [31:0] checks;
    logic [31:0] impossible;
    logic [31:0] implausible;
    logic [31:0] physics;
  } verdict_t;

  string phrase_text [PHRASES] = '{
    "perpetual motion", "faster than light", "infinite energy", "time travel",
    "teleport", "antigravity", "unlimited", "infinite resource", "costless",
    "free energy", "microscopic universe", "infinitely large", "zero volume",
    "instant construction"
  };

  kind_t phrase_group [PHRASES] = '{
    KIND_PHYSICS, KIND_PHYSICS, KIND_PHYSICS, KIND_PHYSICS, KIND_PHYSICS, KIND_PHYSICS,
    KIND_RESOURCE, KIND_RESOURCE, KIND_RESOURCE, KIND_RESOURCE,
    KIND_SCALE, KIND_SCALE, KIND_SCALE, KIND_SCALE
  };

  logic [WIN_BITS-1:0] window_bytes;
  logic                seen_physics;
  logic                seen_resource;
  logic                seen_scale;
  logic [31:0]         n_checks;
  logic [31:0]         n_impossible;
  logic [31:0]         n_implausible;
  logic [31:0]         n_physics;
  verdict_t            verdict_q [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Newest byte sits in bits [7:0].
  function automatic logic phrase_ends_here(input logic [WIN_BITS-1:0] w, input string p);
    int   n;
    logic hit;
    n   = p.len();
    hit = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (w[8*(n-1-i) +: 8] != p[i]) hit = 1'b0;
    end
    return hit;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    verdict_t head;
    verdict_t next_verdict;
    if (rst) begin
      window_bytes  = '0;
      seen_physics  = 1'b0;
      seen_resource = 1'b0;
      seen_scale    = 1'b0;
      n_checks      = '0;
      n_impossible  = '0;
      n_implausible = '0;
      n_physics     = '0;
      verdict_q.delete();
    end else begin
      if (m_valid && m_ready) begin
        if (verdict_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with no verdict pending, data %h", $time, m_data);
          mismatches++;
        end else begin
          head = verdict_q.pop_front();
          check_field("level", 32'(head.level), 32'(m_data[1:0]));
          check_field("violation_kind", 32'(head.kind), 32'(m_data[3:2]));
          check_field("feasible", 32'(head.feasible), 32'(m_data[4]));
          check_field("score_percent", 32'(head.score), 32'(m_data[11:5]));
          check_field("checks_total", head.checks, m_data[43:12]);
          check_field("impossible_total", head.impossible, m_data[75:44]);
          check_field("implausible_total", head.implausible, m_data[107:76]);
          check_field("physics_total", head.physics, m_data[139:108]);
        end
      end
      if (s_valid && s_ready) begin
        if (s_user) begin
          window_bytes = {window_bytes[WIN_BITS-9:0], s_data};
          for (int k = 0; k < PHRASES; k++) begin
            if (phrase_ends_here(window_bytes, phrase_text[k])) begin
              case (phrase_group[k])
                KIND_PHYSICS:  seen_physics  = 1'b1;
                KIND_RESOURCE: seen_resource = 1'b1;
                default:       seen_scale    = 1'b1;
              endcase
            end
          end
        end
        if (s_last) begin
          n_checks++;
          next_verdict.level    = LEVEL_PLAUSIBLE;
          next_verdict.kind     = KIND_NONE;
          next_verdict.feasible = 1'b1;
          next_verdict.score    = SCORE_NONE;
          if (seen_physics) begin
            next_verdict.level    = LEVEL_IMPOSSIBLE;
            next_verdict.kind     = KIND_PHYSICS;
            next_verdict.feasible = 1'b0;
            next_verdict.score    = SCORE_PHYSICS;
            n_physics++;
            n_impossible++;
          end else if (seen_resource) begin
            next_verdict.level = LEVEL_IMPLAUSIBLE;
            next_verdict.kind  = KIND_RESOURCE;
            next_verdict.score = SCORE_RESOURCE;
            n_implausible++;
          end else if (seen_scale) begin
            next_verdict.level = LEVEL_IMPLAUSIBLE;
            next_verdict.kind  = KIND_SCALE;
            next_verdict.score = SCORE_SCALE;
            n_implausible++;
          end
          next_verdict.checks      = n_checks;
          next_verdict.impossible  = n_impossible;
          next_verdict.implausible = n_implausible;
          next_verdict.physics     = n_physics;
          verdict_q.push_back(next_verdict);
          window_bytes  = '0;
          seen_physics  = 1'b0;
          seen_resource = 1'b0;
          seen_scale    = 1'b0;
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

FILE: sim/tb_keyword_plausibility_classifier.sv
// Testbench top for the keyword plausibility classifier: clock, reset, statement stimulus and verdict.
module tb_keyword_plausibility_classifier;
  import kpc_pkg::*;

  typedef logic [7:0] text_t [$];

  typedef enum int {
    MUT_CLEAN,
    MUT_CASE_FLIP,
    MUT_RANDOM_BYTE,
    MUT_TRUNCATE,
    MUT_ZERO_BYTE
  } mutation_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic [7:0]               in_data   = '0;
  logic                     in_user   = 1'b0;
  logic                     in_last   = 1'b0;
  logic                     out_ready = 1'b0;
  logic                     in_ready;
  logic                     out_valid;
  logic [OUT_DATA_BITS-1:0] out_data;

  int mismatches;
  int pending;
  int results_taken = 0;
  int items_sent    = 0;
  int statements    = 0;
  bit sender_calm   = 1'b0;

  string stim_phrases [14] = '{
    "perpetual motion", "faster than light", "infinite energy", "time travel",
    "teleport", "antigravity", "unlimited", "infinite resource", "costless",
    "free energy", "microscopic universe", "infinitely large", "zero volume",
    "instant construction"
  };

  keyword_plausibility_classifier dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_data),
    .s_axis_tuser  (in_user),
    .s_axis_tlast  (in_last),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data)
  );

  kpc_verdict_checker verdict_check (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (in_valid),
    .s_ready    (in_ready),
    .s_data     (in_data),
    .s_user     (in_user),
    .s_last     (in_last),
    .m_valid    (out_valid),
    .m_ready    (out_ready),
    .m_data     (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) results_taken <= results_taken + 1;
  end

  function automatic int beat_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 65) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic has_byte, input logic closes);
    int gap;
    gap = beat_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    in_user  <= has_byte;
    in_last  <= closes;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Bare non-closing markers may fall anywhere; they must not break a keyword.
  task automatic send_statement(input text_t txt, input bit close_on_byte);
    int n;
    n = txt.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(txt[i], 1'b1, close_on_byte && (i == n - 1));
    end
    if (!close_on_byte || n == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic append_phrase(inout text_t txt, input string s, input mutation_t how);
    int         pos;
    logic [7:0] c;
    pos = $urandom_range(0, s.len() - 1);
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (i == pos) begin
        case (how)
          MUT_CASE_FLIP:   c = c ^ 8'h20;
          MUT_RANDOM_BYTE: c = 8'($urandom_range(0, 255));
          default: ;
        endcase
        if (how == MUT_ZERO_BYTE) txt.push_back(8'h00);
      end
      if (!(how == MUT_TRUNCATE && i == s.len() - 1)) txt.push_back(c);
    end
  endtask

  task automatic build_statement(output text_t txt, output bit close_on_byte);
    int r;
    int segs;
    int len;
    txt = {};
    close_on_byte = ($urandom_range(0, 1) == 1);
    r = $urandom_range(0, 99);
    if (r < 10) begin
      len = $urandom_range(1, 20);
      repeat (len) txt.push_back(8'($urandom_range(0, 255)));
    end else if (r >= 20) begin
      segs = $urandom_range(1, 3);
      repeat (segs) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          append_phrase(txt, stim_phrases[$urandom_range(0, 13)], MUT_CLEAN);
        end else if (r < 65) begin
          append_phrase(txt, stim_phrases[$urandom_range(0, 13)],
                        mutation_t'($urandom_range(MUT_CASE_FLIP, MUT_ZERO_BYTE)));
        end else begin
          len = $urandom_range(1, 6);
          repeat (len) begin
            r = $urandom_range(0, 9);
            if (r == 0) txt.push_back(8'h20);
            else if (r == 1) txt.push_back(8'(8'h41 + $urandom_range(0, 25)));
            else txt.push_back(8'(8'h61 + $urandom_range(0, 25)));
          end
        end
      end
    end
  endtask

  initial begin
    int stall;
    bit squeezed;
    bit calm;
    stall    = 0;
    squeezed = 1'b0;
    calm     = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!squeezed && results_taken >= 6) begin
        squeezed = 1'b1;
        stall    = 400;
      end else if (stall == 0) begin
        if ($urandom_range(0, 49) == 0) calm = ~calm;
        if (!calm && $urandom_range(0, 99) < 30)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    text_t txt;
    bit    close_on_byte;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_beat(8'h00, 1'b0, 1'b1);
    txt = {};
    append_phrase(txt, "teleport", MUT_CLEAN);
    send_statement(txt, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    txt = {};
    append_phrase(txt, "costless", MUT_CLEAN);
    send_statement(txt, 1'b0);

    while (items_sent < 600 || statements < 30) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      build_statement(txt, close_on_byte);
      send_statement(txt, close_on_byte);
      statements++;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
